// ===== sv/hbl_pkg.sv =====
// hbl_pkg: shared types, constants and the log-sum-exp merge for the
// log-domain backward pass; no dependencies
package hbl_pkg;

    localparam int NUM_STATES     = 16;
    localparam int MAX_LENGTH     = 1024;
    localparam int LSE_TABLE_SIZE = 256;

    localparam int SW   = $clog2(NUM_STATES);
    localparam int PW   = $clog2(MAX_LENGTH + 1);
    localparam int EW   = $clog2(MAX_LENGTH);
    localparam int BAW  = SW + PW;
    localparam int EAW  = SW + EW;
    localparam int LIW  = $clog2(LSE_TABLE_SIZE);
    localparam int STEP = 12;

    localparam logic signed [31:0] NEG_INF = 32'sh8000_0000;
    localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] NEG_MIN = 32'sh8000_0001;

    localparam logic [1:0] REQ_LOAD_T = 2'd0;
    localparam logic [1:0] REQ_LOAD_E = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;
    localparam logic [1:0] REQ_READ   = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [3:0]         from_state;
        logic [3:0]         to_state;
        logic [10:0]        position;
        logic signed [31:0] log_value;
        logic [10:0]        seq_length;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               is_total;
    } out_beat_t;

    typedef struct packed {
        logic          valid;
        logic          first;
        logic          last;
        logic          init;
        logic          skip;
        logic [SW-1:0] l;
        logic signed [33:0] sum;
    } tok_t;

    typedef struct packed {
        logic               valid;
        logic [SW-1:0]      from;
        logic [SW-1:0]      to;
        logic signed [31:0] value;
    } tload_t;

    typedef struct packed {
        logic               valid;
        logic [SW-1:0]      state;
        logic signed [31:0] data;
    } wr_t;

    typedef logic signed [31:0] lse_tab_t [LSE_TABLE_SIZE];

    // shift-subtract quotient, evaluated while the table is built
    function automatic longint unsigned udiv64(
        input longint unsigned num,
        input longint unsigned den
    );
        longint unsigned q;
        longint unsigned rem;
        q   = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic lse_tab_t build_lse();
        lse_tab_t         tab;
        longint unsigned  pos_sum;
        longint unsigned  neg_sum;
        longint unsigned  term;
        longint unsigned  e1;
        longint unsigned  y;
        longint unsigned  z;
        longint unsigned  z2;
        longint unsigned  p;
        longint unsigned  s;
        longint unsigned  r;
        int               k;
        pos_sum = 64'd1 << 30;
        neg_sum = 64'd0;
        term    = 64'd1 << 30;
        for (int n = 1; n <= 14; n++) begin
            term = udiv64(term, 64'd16 * longint'(n));
            if ((n & 1) == 1) neg_sum += term;
            else pos_sum += term;
        end
        e1 = pos_sum - neg_sum;
        y  = 64'd1 << 30;
        for (int i = 0; i < LSE_TABLE_SIZE; i++) begin
            z  = udiv64(y << 30, (64'd2 << 30) + y);
            z2 = (z * z) >> 30;
            p  = z;
            s  = 64'd0;
            k  = 0;
            while (p != 0 && k < 64) begin
                s += udiv64(p, 64'd2 * longint'(k) + 64'd1);
                p = (p * z2) >> 30;
                k++;
            end
            r = (64'd2 * s + (64'd1 << 13)) >> 14;
            tab[i] = r[31:0];
            y = (y * e1 + (64'd1 << 29)) >> 30;
        end
        return tab;
    endfunction

    localparam lse_tab_t LSE_C = build_lse();

    function automatic logic signed [31:0] lse2(
        input logic signed [31:0] a,
        input logic signed [31:0] b
    );
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        logic [32:0]        diff;
        logic [32-STEP:0]   idx;
        logic signed [32:0] corr;
        logic signed [32:0] r;
        if (a == NEG_INF) return b;
        if (b == NEG_INF) return a;
        hi   = (a > b) ? a : b;
        lo   = (a > b) ? b : a;
        diff = {hi[31], hi} - {lo[31], lo};
        idx  = diff[32:STEP];
        corr = (idx < LSE_TABLE_SIZE) ? {LSE_C[idx[LIW-1:0]][31], LSE_C[idx[LIW-1:0]]}
                                      : 33'sd0;
        r    = {hi[31], hi} + corr;
        if (r > $signed({POS_MAX[31], POS_MAX})) return POS_MAX;
        return r[31:0];
    endfunction

endpackage

// ===== sv/hmm_backward_log_domain.sv =====
// hmm_backward_log_domain: top level; sequencer, emission and backward
// memories, output register; uses hbl_pkg and hbl_chain
//
// Loads are taken while the sequencer idles; a read result passes the backward
// memory's read register, then the output register. A start beat of length L
// (clamped to 1024) holds the input until the pass ends: each column sends 15
// beats down the row of 16 cells, then waits for the last cell to write the
// column back, since the next column reads it from the single backward memory.
module hmm_backward_log_domain
    import hbl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_INIT = 3'd2;
    localparam logic [2:0] S_FEED = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_TOT  = 3'd5;
    localparam logic [2:0] S_TOTD = 3'd6;

    localparam int WAIT_CYC = NUM_STATES + 8;
    localparam int WCW      = $clog2(WAIT_CYC + 1);

    logic [2:0]         state_reg, state_next;
    logic [PW-1:0]      col_reg, col_next;
    logic [PW-1:0]      alen_reg, alen_next;
    logic [SW-1:0]      l_reg, l_next;
    logic [WCW-1:0]     wcnt_reg, wcnt_next;
    logic               oob_reg, oob_next;
    logic               m_valid_reg;
    out_beat_t          m_data_reg;

    logic signed [31:0] bmem [2**BAW];
    logic signed [31:0] emem [2**EAW];
    logic signed [31:0] b_rdata_reg;
    logic signed [31:0] e_rdata_reg;
    logic [BAW-1:0]     b_raddr;
    logic [EAW-1:0]     e_raddr;

    logic               acc_in;
    logic [PW-1:0]      len_clamp;
    tload_t             tload;
    tok_t               iss_next, iss_reg;
    tok_t               head_reg;
    wr_t                wr;

    assign acc_in    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE) && !(m_valid_reg && !m_ready);
    assign len_clamp = (s_data.seq_length > PW'(MAX_LENGTH)) ? PW'(MAX_LENGTH)
                                                              : s_data.seq_length;

    assign tload.valid = acc_in && s_data.req_type == REQ_LOAD_T
                         && 32'(s_data.from_state) < NUM_STATES
                         && 32'(s_data.to_state) < NUM_STATES;
    assign tload.from  = s_data.from_state[SW-1:0];
    assign tload.to    = s_data.to_state[SW-1:0];
    assign tload.value = s_data.log_value;

    always_comb begin
        state_next = state_reg;
        col_next   = col_reg;
        alen_next  = alen_reg;
        l_next     = l_reg;
        wcnt_next  = wcnt_reg;
        oob_next   = oob_reg;
        iss_next   = '0;
        b_raddr    = '0;
        e_raddr    = {l_reg, col_reg[EW-1:0]};
        unique case (state_reg)
            S_IDLE: begin
                b_raddr = {s_data.from_state[SW-1:0], s_data.position};
                if (acc_in) begin
                    case (s_data.req_type)
                        REQ_START: begin
                            col_next   = len_clamp;
                            alen_next  = len_clamp;
                            state_next = S_INIT;
                        end
                        REQ_READ: begin
                            oob_next   = 32'(s_data.from_state) >= NUM_STATES
                                         || s_data.position > alen_reg;
                            state_next = S_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                state_next = S_IDLE;
            end
            S_INIT: begin
                iss_next.valid = 1'b1;
                iss_next.init  = 1'b1;
                wcnt_next      = WCW'(WAIT_CYC);
                state_next     = S_WAIT;
            end
            S_FEED: begin
                b_raddr        = {l_reg, col_reg + PW'(1)};
                iss_next.valid = 1'b1;
                iss_next.first = (l_reg == SW'(1));
                iss_next.last  = (l_reg == SW'(NUM_STATES - 1));
                iss_next.l     = l_reg;
                l_next         = l_reg + SW'(1);
                if (l_reg == SW'(NUM_STATES - 1)) begin
                    wcnt_next  = WCW'(WAIT_CYC);
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                wcnt_next = wcnt_reg - WCW'(1);
                if (wcnt_reg == '0) begin
                    if (col_reg == '0) begin
                        state_next = S_TOT;
                    end else begin
                        col_next   = col_reg - PW'(1);
                        l_next     = SW'(1);
                        state_next = S_FEED;
                    end
                end
            end
            S_TOT: begin
                b_raddr    = '0;
                state_next = S_TOTD;
            end
            S_TOTD: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            alen_reg  <= '0;
            iss_reg.valid  <= 1'b0;
            head_reg.valid <= 1'b0;
        end else begin
            state_reg <= state_next;
            alen_reg  <= alen_next;
            iss_reg.valid  <= iss_next.valid;
            head_reg.valid <= iss_reg.valid;
        end
        col_reg  <= col_next;
        l_reg    <= l_next;
        wcnt_reg <= wcnt_next;
        oob_reg  <= oob_next;
        iss_reg.first <= iss_next.first;
        iss_reg.last  <= iss_next.last;
        iss_reg.init  <= iss_next.init;
        iss_reg.skip  <= 1'b0;
        iss_reg.l     <= iss_next.l;
        iss_reg.sum   <= '0;
        head_reg.first <= iss_reg.first;
        head_reg.last  <= iss_reg.last;
        head_reg.init  <= iss_reg.init;
        head_reg.skip  <= (b_rdata_reg == NEG_INF) || (e_rdata_reg == NEG_INF);
        head_reg.l     <= iss_reg.l;
        head_reg.sum   <= {{2{b_rdata_reg[31]}}, b_rdata_reg}
                        + {{2{e_rdata_reg[31]}}, e_rdata_reg};
    end

    always_ff @(posedge aclk) begin
        if (wr.valid) begin
            bmem[{wr.state, col_reg}] <= wr.data;
        end
        b_rdata_reg <= bmem[b_raddr];
    end

    always_ff @(posedge aclk) begin
        if (acc_in && s_data.req_type == REQ_LOAD_E
            && 32'(s_data.from_state) < NUM_STATES
            && 32'(s_data.position) < MAX_LENGTH) begin
            emem[{s_data.from_state[SW-1:0], s_data.position[EW-1:0]}] <= s_data.log_value;
        end
        e_rdata_reg <= emem[e_raddr];
    end

    hbl_chain u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tload    (tload),
        .tok_head (head_reg),
        .wr       (wr)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_RD || state_reg == S_TOTD) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (state_reg == S_RD) begin
            m_data_reg.result_value <= oob_reg ? NEG_INF : b_rdata_reg;
            m_data_reg.is_total     <= 1'b0;
        end else if (state_reg == S_TOTD) begin
            m_data_reg.result_value <= b_rdata_reg;
            m_data_reg.is_total     <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_wr_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.valid |-> state_reg == S_WAIT)
        else $error("column write outside the drain wait");
    a_feed_end: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FEED && l_reg == SW'(NUM_STATES - 1) |=> state_reg == S_WAIT)
        else $error("column feed did not end after the last state");
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_in && s_data.req_type == REQ_START |=> state_reg == S_INIT)
        else $error("start beat did not begin a pass");
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RD || state_reg == S_TOTD |-> !m_valid_reg || m_ready)
        else $error("result would overwrite an untaken beat");
`endif

endmodule

// ===== sv/hbl_cell.sv =====
// hbl_cell: one state's cell; holds its transition row, adds it to the
// passing beat and merges into its accumulator; uses hbl_pkg
module hbl_cell
    import hbl_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [SW-1:0]      cell_idx,
    input  tload_t             tload,
    input  tok_t               tok_in,
    output tok_t               tok_out,
    output logic               res_valid,
    output logic signed [31:0] res_data
);

    logic signed [31:0] tr_row [NUM_STATES];
    tok_t               tok_reg;

    logic               t2_valid_reg;
    logic               t2_first_reg;
    logic               t2_last_reg;
    logic               t2_init_reg;
    logic               t2_skip_reg;
    logic signed [31:0] t2_term_reg;
    logic signed [31:0] acc_reg;
    logic               res_valid_reg;
    logic signed [31:0] res_reg;

    logic signed [31:0] tr;
    logic signed [33:0] term_full;
    logic signed [31:0] term_sat;
    logic signed [31:0] acc_base;
    logic signed [31:0] acc_next;

    always_ff @(posedge aclk) begin
        if (tload.valid && tload.from == cell_idx) begin
            tr_row[tload.to] <= tload.value;
        end
    end

    assign tr        = tr_row[tok_reg.l];
    assign term_full = tok_reg.sum + {{2{tr[31]}}, tr};

    always_comb begin
        if (term_full > 34'sd2147483647) begin
            term_sat = POS_MAX;
        end else if (term_full <= -34'sd2147483648) begin
            term_sat = NEG_MIN;
        end else begin
            term_sat = term_full[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
            t2_valid_reg  <= 1'b0;
        end else begin
            tok_reg.valid <= tok_in.valid;
            t2_valid_reg  <= tok_reg.valid;
        end
        tok_reg.first <= tok_in.first;
        tok_reg.last  <= tok_in.last;
        tok_reg.init  <= tok_in.init;
        tok_reg.skip  <= tok_in.skip;
        tok_reg.l     <= tok_in.l;
        tok_reg.sum   <= tok_in.sum;
        t2_first_reg  <= tok_reg.first;
        t2_last_reg   <= tok_reg.last;
        t2_init_reg   <= tok_reg.init;
        t2_skip_reg   <= tok_reg.skip || (tr == NEG_INF);
        t2_term_reg   <= tok_reg.init ? tr_row[0] : term_sat;
    end

    assign tok_out = tok_reg;

    assign acc_base = t2_first_reg ? NEG_INF : acc_reg;
    assign acc_next = t2_skip_reg ? acc_base : lse2(acc_base, t2_term_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= t2_valid_reg && (t2_init_reg || t2_last_reg);
        end
        if (t2_valid_reg && !t2_init_reg) begin
            acc_reg <= acc_next;
        end
        res_reg <= t2_init_reg ? t2_term_reg : acc_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

// ===== sv/hbl_chain.sv =====
// hbl_chain: row of hbl_cell instances, one per state, and the collector
// that turns their staggered results into one write a cycle; uses hbl_pkg
module hbl_chain
    import hbl_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  tload_t tload,
    input  tok_t   tok_head,
    output wr_t    wr
);

    tok_t               tok [NUM_STATES+1];
    logic               rv  [NUM_STATES];
    logic signed [31:0] rd  [NUM_STATES];
    wr_t                wr_next;
    wr_t                wr_reg;

    assign tok[0] = tok_head;

    for (genvar g = 0; g < NUM_STATES; g++) begin : g_cell
        hbl_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (SW'(g)),
            .tload     (tload),
            .tok_in    (tok[g]),
            .tok_out   (tok[g+1]),
            .res_valid (rv[g]),
            .res_data  (rd[g])
        );
    end

    always_comb begin
        wr_next = '0;
        for (int k = 0; k < NUM_STATES; k++) begin
            if (rv[k]) begin
                wr_next.valid = 1'b1;
                wr_next.state = wr_next.state | SW'(k);
                wr_next.data  = wr_next.data | rd[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg.valid <= 1'b0;
        end else begin
            wr_reg.valid <= wr_next.valid;
        end
        wr_reg.state <= wr_next.state;
        wr_reg.data  <= wr_next.data;
    end

    assign wr = wr_reg;

`ifndef NO_ASSERTIONS
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({rv[15], rv[14], rv[13], rv[12], rv[11], rv[10], rv[9], rv[8],
                    rv[7], rv[6], rv[5], rv[4], rv[3], rv[2], rv[1], rv[0]}) <= 1)
        else $error("two cells finished in one cycle");
    a_tok_last: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_head.valid && tok_head.last |=> !tok_head.valid || tok_head.first
                                         || tok_head.init)
        else $error("beat after last of a column is not a new column");
    a_wr_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_next.valid |=> wr.valid)
        else $error("collector dropped a result");
`endif

endmodule

// ===== tb/sv/hbl_scoreboard.sv =====
// hbl_scoreboard: watches both channels of hmm_backward_log_domain, keeps its
// own copy of the tables, runs the backward pass and checks every result beat
// depends on hbl_pkg
`timescale 1ns / 1ps

module hbl_scoreboard
    import hbl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_beat_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_beat_t m_data,
    output int        fail_count,
    output int        pending
);

    localparam int COLS = MAX_LENGTH + 1;

    logic signed [31:0] corr_tab [LSE_TABLE_SIZE];
    logic signed [31:0] trans_mem [NUM_STATES * NUM_STATES];
    logic signed [31:0] emit_mem [NUM_STATES * MAX_LENGTH];
    logic signed [31:0] beta_mem [NUM_STATES * COLS];
    int unsigned        cur_len;
    out_beat_t          want_q [$];

    function automatic void fill_corr();
        longint unsigned pos_acc, neg_acc, term, e1, y, z, z2, p, s, c;
        pos_acc = 64'd1 << 30;
        neg_acc = 0;
        term    = 64'd1 << 30;
        for (int n = 1; n <= 14; n++) begin
            term = term / (64'd16 * n);
            if (n % 2) neg_acc += term;
            else pos_acc += term;
        end
        e1 = pos_acc - neg_acc;
        y  = 64'd1 << 30;
        for (int i = 0; i < LSE_TABLE_SIZE; i++) begin
            z  = (y << 30) / ((64'd2 << 30) + y);
            z2 = (z * z) >> 30;
            p  = z;
            s  = 0;
            for (int k = 0; p != 0 && k < 64; k++) begin
                s += p / (64'd2 * k + 1);
                p = (p * z2) >> 30;
            end
            c = (64'd2 * s + 64'd8192) >> 14;
            corr_tab[i] = c[31:0];
            y = (y * e1 + (64'd1 << 29)) >> 30;
        end
    endfunction

    function automatic logic signed [31:0] log_add(logic signed [31:0] a,
                                                   logic signed [31:0] b);
        longint hi, lo, d, r;
        if (a == NEG_INF) return b;
        if (b == NEG_INF) return a;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        d  = (hi - lo) >>> 12;
        r  = hi + ((d < LSE_TABLE_SIZE) ? longint'(corr_tab[d]) : 0);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        return r[31:0];
    endfunction

    function automatic void backward_pass(int unsigned len);
        logic signed [31:0] acc, nx, tr, em;
        longint t;
        for (int k = 0; k < NUM_STATES; k++)
            beta_mem[k * COLS + len] = trans_mem[k * NUM_STATES];
        for (int i = int'(len) - 1; i >= 0; i--) begin
            for (int k = 0; k < NUM_STATES; k++) begin
                acc = NEG_INF;
                for (int l = 1; l < NUM_STATES; l++) begin
                    nx = beta_mem[l * COLS + i + 1];
                    tr = trans_mem[k * NUM_STATES + l];
                    em = emit_mem[l * MAX_LENGTH + i];
                    if (nx == NEG_INF || tr == NEG_INF || em == NEG_INF) continue;
                    t = longint'(nx) + longint'(tr) + longint'(em);
                    if (t > 64'sd2147483647) t = 64'sd2147483647;
                    if (t <= -64'sd2147483648) t = -64'sd2147483647;
                    acc = log_add(acc, t[31:0]);
                end
                beta_mem[k * COLS + i] = acc;
            end
        end
        cur_len = len;
    endfunction

    initial begin
        fill_corr();
    end

    always @(posedge aclk) begin
        out_beat_t   w;
        int unsigned len;
        if (!aresetn) begin
            fail_count = 0;
            pending    = 0;
            cur_len    = 0;
            want_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (want_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat: value %0d total %0d",
                                 m_data.result_value, m_data.is_total);
                end else begin
                    w = want_q.pop_front();
                    if (w.result_value !== m_data.result_value ||
                        w.is_total !== m_data.is_total) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: value exp %0d got %0d, total exp %0d got %0d",
                                     w.result_value, m_data.result_value,
                                     w.is_total, m_data.is_total);
                    end
                end
            end
            if (s_valid && s_ready) begin
                case (s_data.req_type)
                    REQ_LOAD_T:
                        trans_mem[s_data.from_state * NUM_STATES + s_data.to_state] =
                            s_data.log_value;
                    REQ_LOAD_E:
                        if (s_data.position < MAX_LENGTH)
                            emit_mem[s_data.from_state * MAX_LENGTH + s_data.position] =
                                s_data.log_value;
                    REQ_START: begin
                        len = (s_data.seq_length > MAX_LENGTH) ? MAX_LENGTH : s_data.seq_length;
                        backward_pass(len);
                        w.result_value = beta_mem[0];
                        w.is_total     = 1'b1;
                        want_q = {want_q, w};
                    end
                    REQ_READ: begin
                        if (s_data.position <= cur_len && s_data.position <= MAX_LENGTH)
                            w.result_value = beta_mem[s_data.from_state * COLS + s_data.position];
                        else
                            w.result_value = NEG_INF;
                        w.is_total = 1'b0;
                        want_q = {want_q, w};
                    end
                endcase
            end
            pending = want_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_hmm_backward_log_domain.sv =====
// tb_hmm_backward_log_domain: clock, reset and beat stimulus for the backward
// pass block with random idling on both channels; checking is in hbl_scoreboard
// depends on hbl_pkg, hbl_scoreboard and hmm_backward_log_domain
`timescale 1ns / 1ps

module tb_hmm_backward_log_domain;
    import hbl_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int FILL_LEN    = 48;
    localparam int N_RAND      = 440;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;
    int        fail_count;
    int        pending;
    int        cycles;
    int        rx_hold;
    bit        tx_busy_gaps;
    int        last_len;

    hmm_backward_log_domain uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    hbl_scoreboard chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // result side: random stalls, plus long holds requested by the stimulus
    initial begin
        m_ready = 1'b0;
        rx_hold = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                rx_hold--;
            end else if ($urandom_range(0, 9) < 7) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                     : $urandom_range(0, 3);
            end
        end
    end

    function automatic logic signed [31:0] rand_log();
        case ($urandom_range(0, 19))
            0: return NEG_INF;
            1: return $urandom;
            2: return POS_MAX;
            3: return $urandom_range(0, 2 << 16);
            4: return NEG_MIN;
            default: return -$signed({1'b0, 31'($urandom_range(0, 6 << 16))});
        endcase
    endfunction

    // caller sits at a falling edge; returns at a falling edge
    task automatic send_beat(in_beat_t b);
        int gap;
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (b.req_type == REQ_START)
            last_len = (b.seq_length > MAX_LENGTH) ? MAX_LENGTH : b.seq_length;
        gap = 0;
        if (tx_busy_gaps) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: gap = 0;
                9: gap = $urandom_range(10, 40);
                default: gap = $urandom_range(1, 3);
            endcase
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    function automatic in_beat_t mk(logic [1:0] req, int from, int to, int pos,
                                    logic signed [31:0] val, int len);
        in_beat_t b;
        b.req_type   = req;
        b.from_state = 4'(from);
        b.to_state   = 4'(to);
        b.position   = 11'(pos);
        b.log_value  = val;
        b.seq_length = 11'(len);
        return b;
    endfunction

    function automatic in_beat_t rand_beat();
        in_beat_t b;
        int r;
        b = mk(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
        r = $urandom_range(0, 99);
        if (r < 28) begin
            b.req_type  = REQ_LOAD_T;
            b.log_value = rand_log();
        end else if (r < 58) begin
            b.req_type  = REQ_LOAD_E;
            b.position  = ($urandom_range(0, 19) == 0) ? 11'($urandom)
                                                       : 11'($urandom_range(0, 15));
            b.log_value = rand_log();
        end else if (r < 68) begin
            b.req_type = REQ_START;
            case ($urandom_range(0, 49))
                0: b.seq_length = 11'(FILL_LEN);
                1, 2, 3: b.seq_length = 11'($urandom_range(0, FILL_LEN));
                default: b.seq_length = 11'($urandom_range(0, 10));
            endcase
        end else begin
            b.req_type = REQ_READ;
            b.position = ($urandom_range(0, 9) == 0) ? 11'($urandom)
                                                     : 11'($urandom_range(0, last_len + 1));
        end
        return b;
    endfunction

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        tx_busy_gaps = 1'b0;
        last_len     = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // fill every table entry a pass can touch; passes stay within FILL_LEN
        for (int f = 0; f < NUM_STATES; f++)
            for (int t = 0; t < NUM_STATES; t++)
                send_beat(mk(REQ_LOAD_T, f, t, $urandom, rand_log(), $urandom));
        for (int st = 0; st < NUM_STATES; st++)
            for (int p = 0; p < FILL_LEN; p++)
                send_beat(mk(REQ_LOAD_E, st, $urandom, p,
                             -$signed({1'b0, 31'($urandom_range(0, 4 << 16))}), $urandom));

        // directed corners
        tx_busy_gaps = 1'b1;
        send_beat(mk(REQ_START, 0, 0, 0, 0, 0));
        send_beat(mk(REQ_READ, 5, 0, 0, 0, 0));
        send_beat(mk(REQ_READ, 5, 0, 1, 0, 0));
        send_beat(mk(REQ_START, 0, 0, 0, 0, 1));
        send_beat(mk(REQ_LOAD_E, 3, 0, 1024, NEG_INF, 0));
        send_beat(mk(REQ_LOAD_E, 15, 15, 2047, POS_MAX, 2047));
        send_beat(mk(REQ_LOAD_T, 1, 2, 0, POS_MAX, 0));
        send_beat(mk(REQ_LOAD_T, 2, 3, 0, NEG_MIN, 0));
        send_beat(mk(REQ_LOAD_E, 7, 0, 0, NEG_INF, 0));
        send_beat(mk(REQ_START, 0, 0, 0, 0, FILL_LEN));
        send_beat(mk(REQ_READ, 15, 0, FILL_LEN, 0, 0));
        send_beat(mk(REQ_READ, 0, 0, FILL_LEN + 1, 0, 0));
        send_beat(mk(REQ_READ, 15, 15, 2047, 32'hffffffff, 2047));
        send_beat(mk(REQ_START, 0, 0, 0, 0, FILL_LEN - 1));
        // empty sum: state 0 cannot reach any emitting state
        for (int l = 1; l < NUM_STATES; l++)
            send_beat(mk(REQ_LOAD_T, 0, l, 0, NEG_INF, 0));
        send_beat(mk(REQ_START, 0, 0, 0, 0, 3));
        send_beat(mk(REQ_READ, 0, 0, 2, 0, 0));

        for (int n = 0; n < N_RAND; n++) begin
            if (n == 150) rx_hold = 400;
            if (n == 300) begin
                wait (pending == 0);
                @(negedge aclk);
            end
            tx_busy_gaps = !(n >= 50 && n < 100);
            send_beat(rand_beat());
        end
        s_valid <= 1'b0;

        wait (pending == 0);
        repeat (60) @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
